// ===== design/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA pixel decoder package
// Shared types and constants for the TGA truecolor stream decoder: result
// kinds, header byte positions, file format codes and bus widths.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Result kinds, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_HEADER      = 2'd0,
    KIND_PIXEL       = 2'd1,
    KIND_UNSUPPORTED = 2'd2,
    KIND_OVERFLOW    = 2'd3
  } kind_e;

  // Bus widths.
  localparam int InDataW  = 8;
  localparam int InUserW  = 1;
  localparam int OutDataW = 80;
  localparam int OutUserW = 2;
  localparam int PayloadW = 75;
  localparam int AddrW    = 3;
  localparam int ApbDataW = 32;

  // Register map (word index taken from paddr[2]).
  localparam logic RegSwapOrder = 1'b0;

  // Image types and pixel depths.
  localparam logic [7:0] TypeRaw = 8'd2;
  localparam logic [7:0] TypeRle = 8'd10;
  localparam logic [7:0] Depth24 = 8'd24;
  localparam logic [7:0] RunBias = 8'd127;

  // Header byte positions.
  localparam logic [4:0] HdrIdLen   = 5'd0;
  localparam logic [4:0] HdrType    = 5'd2;
  localparam logic [4:0] HdrCmLenLo = 5'd5;
  localparam logic [4:0] HdrCmLenHi = 5'd6;
  localparam logic [4:0] HdrEntry   = 5'd7;
  localparam logic [4:0] HdrWidthLo = 5'd12;
  localparam logic [4:0] HdrWidthHi = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth   = 5'd16;
  localparam logic [4:0] HdrLast    = 5'd17;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic        last_pixel;
    logic [2:0]  pixel_bytes;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [7:0]  repeat_count;
    logic [7:0]  alpha_channel;
    logic [7:0]  third_channel;
    logic [7:0]  second_channel;
    logic [7:0]  first_channel;
  } res_t;

endpackage

// ===== design/tga_rle_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// TGA truecolor RLE pixel decoder
// Parses a TGA byte stream (types 2 and 10), skips id and palette bytes and
// returns header info, pixels or pixel runs, and error results.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one file byte per transfer in s_axis_tdata; its
//   tuser bit marks the first header byte of a new file and always restarts
//   header parsing. The master stream returns at most one result per input
//   byte: tuser holds the kind (header info, pixel run, unsupported type,
//   pixel overflow), tlast is set on the run that completes the image.
//   A result is valid in the cycle after the byte that caused it was
//   transferred. Throughput is one byte per cycle while results are taken;
//   every byte passes through one decode step between the state registers
//   and the result register. The header decode at byte 17 holds the two
//   small multipliers for the pixel count and the palette skip length.
//   When the receiver stalls, the result register holds its item and the
//   slave tready drops until the result is taken. After reset no result
//   is pending, the decoder waits for a byte marked as a file start, and
//   swap_order reads 1 (file B,G,R comes out as R,G,B). The user must write
//   swap_order over the APB port at address 0 only while idle (not enforced).
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trd_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] file_byte
  input  logic [trd_pkg::InUserW-1:0]   s_axis_tuser,  // [0] start_file
  // Results out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] first_channel, [15:8] second_channel, [23:16] third_channel,
  // [31:24] alpha_channel, [39:32] repeat_count, [55:40] frame_width,
  // [71:56] frame_height, [74:72] pixel_bytes, [79:75] zero
  output logic [trd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [trd_pkg::OutUserW-1:0]  m_axis_tuser,  // [1:0] kind
  output logic                          m_axis_tlast,  // last_pixel
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trd_pkg::AddrW-1:0]     paddr,
  input  logic [trd_pkg::ApbDataW-1:0]  pwdata,
  output logic [trd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import trd_pkg::*;

  // Decoder phases.
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhHeader = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhHead   = 3'd3;
  localparam logic [2:0] PhPixel  = 3'd4;
  localparam logic [2:0] PhDone   = 3'd5;

  // Control state.
  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [21:0] skip_q, skip_d;
  logic [31:0] pix_rem_q, pix_rem_d;
  logic        pkt_run_q, pkt_run_d;
  logic [7:0]  pkt_rem_q, pkt_rem_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic        swap_q;
  logic        out_valid_q, out_valid_d;

  // Header fields and pixel assembly.
  logic [7:0]  id_len_q, id_len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] cm_len_q, cm_len_d;
  logic [7:0]  entry_q, entry_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic [23:0] hold_q, hold_d;
  res_t        res_q, res_d;

  // Decode helpers.
  logic        accept;
  logic        load_out;
  logic        emit;
  logic        start;
  logic [7:0]  data_byte;
  logic [2:0]  cur_phase;
  logic [4:0]  cur_idx;
  logic [20:0] cm_bytes;
  logic [21:0] skip_total;
  logic [31:0] pix_total;
  logic        size_zero;
  logic [2:0]  pix_phase;
  logic        four_bytes;
  logic [2:0]  pix_bytes;
  logic        pix_last_byte;
  logic [7:0]  ch0, ch1, ch2, alpha;
  logic [7:0]  rep;
  logic [7:0]  pkt_rem_next;

  // Handshakes.
  assign load_out      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = load_out;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = s_axis_tuser[0];
  assign data_byte     = s_axis_tdata;

  // A file start restarts parsing at header byte 0.
  assign cur_phase = start ? PhHeader : phase_q;
  assign cur_idx   = start ? '0 : hdr_idx_q;

  // Header arithmetic, used at the last header byte.
  assign cm_bytes   = 21'(cm_len_q) * 21'(entry_q[7:3]);
  assign skip_total = 22'(id_len_q) + 22'(cm_bytes);
  assign pix_total  = 32'(width_q) * 32'(height_q);
  assign size_zero  = (width_q == '0) || (height_q == '0);
  assign pix_phase  = (type_q == TypeRle) ? PhHead : PhPixel;

  // Pixel format.
  assign four_bytes    = (depth_q != Depth24);
  assign pix_bytes     = four_bytes ? 3'd4 : 3'd3;
  assign pix_last_byte = four_bytes ? (byte_idx_q == 2'd3) : (byte_idx_q == 2'd2);

  // Channel assembly with optional first/third swap.
  always_comb begin
    alpha = four_bytes ? data_byte : 8'd0;
    ch1   = hold_q[15:8];
    if (swap_q) begin
      ch0 = four_bytes ? hold_q[23:16] : data_byte;
      ch2 = hold_q[7:0];
    end else begin
      ch0 = hold_q[7:0];
      ch2 = four_bytes ? hold_q[23:16] : data_byte;
    end
  end

  // Run length of the current packet.
  assign rep          = pkt_run_q ? pkt_rem_q : 8'd1;
  assign pkt_rem_next = pkt_run_q ? 8'd0 : pkt_rem_q - 8'd1;

  // Per-byte decode step.
  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    skip_d     = skip_q;
    pix_rem_d  = pix_rem_q;
    pkt_run_d  = pkt_run_q;
    pkt_rem_d  = pkt_rem_q;
    byte_idx_d = byte_idx_q;
    id_len_d   = id_len_q;
    type_d     = type_q;
    cm_len_d   = cm_len_q;
    entry_d    = entry_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    hold_d     = hold_q;
    emit       = 1'b0;
    res_d      = '0;
    res_d.frame_width  = width_q;
    res_d.frame_height = height_q;
    res_d.pixel_bytes  = pix_bytes;

    if (accept) begin
      if (start) begin
        phase_d   = PhHeader;
        hdr_idx_d = '0;
      end
      unique case (cur_phase)
        PhHeader: begin
          hdr_idx_d = cur_idx + 5'd1;
          // Store the header bytes that matter.
          unique case (cur_idx)
            HdrIdLen:    id_len_d        = data_byte;
            HdrType:     type_d          = data_byte;
            HdrCmLenLo:  cm_len_d[7:0]   = data_byte;
            HdrCmLenHi:  cm_len_d[15:8]  = data_byte;
            HdrEntry:    entry_d         = data_byte;
            HdrWidthLo:  width_d[7:0]    = data_byte;
            HdrWidthHi:  width_d[15:8]   = data_byte;
            HdrHeightLo: height_d[7:0]   = data_byte;
            HdrHeightHi: height_d[15:8]  = data_byte;
            HdrDepth:    depth_d         = data_byte;
            default: ;
          endcase
          if (cur_idx == HdrType && data_byte != TypeRaw && data_byte != TypeRle) begin
            phase_d = PhDone;
            emit    = 1'b1;
            res_d   = '0;
            res_d.kind = KIND_UNSUPPORTED;
          end else if (cur_idx >= HdrLast) begin
            skip_d     = skip_total;
            pix_rem_d  = pix_total;
            emit       = 1'b1;
            res_d.kind = KIND_HEADER;
            byte_idx_d = '0;
            if (skip_total != '0) begin
              phase_d = PhSkip;
            end else begin
              phase_d = size_zero ? PhDone : pix_phase;
              if (type_q != TypeRle) begin
                pkt_run_d = 1'b0;
              end
            end
          end
        end
        PhSkip: begin
          skip_d = skip_q - 22'd1;
          if (skip_q == 22'd1) begin
            byte_idx_d = '0;
            phase_d    = (pix_rem_q == '0) ? PhDone : pix_phase;
            if (type_q != TypeRle) begin
              pkt_run_d = 1'b0;
            end
          end
        end
        PhHead: begin
          // Head byte: run flag in the top bit, length in the rest.
          pkt_run_d  = data_byte[7];
          pkt_rem_d  = data_byte[7] ? data_byte - RunBias : data_byte + 8'd1;
          byte_idx_d = '0;
          phase_d    = PhPixel;
        end
        PhPixel: begin
          if (!pix_last_byte) begin
            // Collect the leading bytes of the pixel.
            byte_idx_d = byte_idx_q + 2'd1;
            case (byte_idx_q)
              2'd0: hold_d[7:0]   = data_byte;
              2'd1: hold_d[15:8]  = data_byte;
              2'd2: hold_d[23:16] = data_byte;
              default: ;
            endcase
          end else begin
            byte_idx_d = '0;
            emit       = 1'b1;
            res_d.first_channel  = ch0;
            res_d.second_channel = ch1;
            res_d.third_channel  = ch2;
            res_d.alpha_channel  = alpha;
            if (type_q != TypeRle) begin
              // Raw image: one pixel per result.
              pix_rem_d          = pix_rem_q - 32'd1;
              res_d.kind         = KIND_PIXEL;
              res_d.repeat_count = 8'd1;
              res_d.last_pixel   = (pix_rem_q == 32'd1);
              if (pix_rem_q == 32'd1) begin
                phase_d = PhDone;
              end
            end else if (32'(rep) > pix_rem_q) begin
              // Packet runs past the image: report and stop.
              phase_d = PhDone;
              res_d.kind           = KIND_OVERFLOW;
              res_d.first_channel  = '0;
              res_d.second_channel = '0;
              res_d.third_channel  = '0;
              res_d.alpha_channel  = '0;
            end else begin
              pix_rem_d          = pix_rem_q - 32'(rep);
              pkt_rem_d          = pkt_rem_next;
              res_d.kind         = KIND_PIXEL;
              res_d.repeat_count = rep;
              res_d.last_pixel   = (pix_rem_q == 32'(rep));
              if (pkt_rem_next == '0) begin
                phase_d = (pix_rem_q == 32'(rep)) ? PhDone : PhHead;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = accept && emit;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_idx_q   <= '0;
      skip_q      <= '0;
      pix_rem_q   <= '0;
      pkt_run_q   <= 1'b0;
      pkt_rem_q   <= '0;
      byte_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      skip_q      <= skip_d;
      pix_rem_q   <= pix_rem_d;
      pkt_run_q   <= pkt_run_d;
      pkt_rem_q   <= pkt_rem_d;
      byte_idx_q  <= byte_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header fields, pixel bytes and the result payload.
  always_ff @(posedge clk_i) begin
    id_len_q <= id_len_d;
    type_q   <= type_d;
    cm_len_q <= cm_len_d;
    entry_q  <= entry_d;
    width_q  <= width_d;
    height_q <= height_d;
    depth_q  <= depth_d;
    hold_q   <= hold_d;
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegSwapOrder) begin
      swap_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSwapOrder) ? {{(ApbDataW-1){1'b0}}, swap_q} : '0;

  // Output stream.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last_pixel;
  assign m_axis_tdata  = {{(OutDataW-PayloadW){1'b0}}, res_q.pixel_bytes,
                          res_q.frame_height, res_q.frame_width, res_q.repeat_count,
                          res_q.alpha_channel, res_q.third_channel,
                          res_q.second_channel, res_q.first_channel};

  // Checks.
  a_stall_only_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_raw_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPixel && type_q != TypeRle) |-> pix_rem_q != '0)
    else $error("raw pixel phase with no pixels left");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.kind == KIND_PIXEL) |-> res_q.repeat_count != '0)
    else $error("pixel result with zero repeat count");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPixel && !four_bytes) |-> byte_idx_q != 2'd3)
    else $error("byte index past a 24-bit pixel");

endmodule
